[rtl/cbd_pkg.sv]
// Shared types and constants for the cached binary-to-decimal converter.
// No dependencies; imported by every module of the block.
package cbd_pkg;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // How the back must produce the digits of a queued number.
    typedef enum logic [1:0] {
        KIND_HIT  = 2'd0,
        KIND_INC  = 2'd1,
        KIND_FULL = 2'd2
    } item_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_CONV = 2'd1,
        BK_DONE = 2'd2
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

[rtl/cbd_fifo.sv]
// Short first-word-fall-through queue between the front and the back.
// Depends on cbd_pkg for the depth and the status struct.
module cbd_fifo #(
    parameter int WIDTH = 34
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    rd_data,
    output cbd_pkg::fifo_stat_t stat
);
    import cbd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[rtl/cbd_front.sv]
// Front end: accepts numbers and classifies each one as a cache hit, an
// increment of the previous number or a full conversion. Depends on cbd_pkg.
module cbd_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_BITS-1:0]  value,
    input  cbd_pkg::fifo_stat_t    q_stat,
    output logic                   push,
    output cbd_pkg::item_kind_t    push_kind,
    output logic [VALUE_BITS-1:0]  push_value
);
    import cbd_pkg::*;

    // Every accepted number becomes the cached number, so the front can
    // track it on its own, ahead of the back.
    logic [VALUE_BITS-1:0] last_num_reg;

    assign in_ready   = !q_stat.full;
    assign push       = in_valid && in_ready;
    assign push_value = value;

    always_comb
    begin
        if (value == last_num_reg)
        begin
            push_kind = KIND_HIT;
        end
        else if ((last_num_reg != '1) && (value == last_num_reg + 1'b1))
        begin
            push_kind = KIND_INC;
        end
        else
        begin
            push_kind = KIND_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_num_reg <= '0;
        end
        else if (push)
        begin
            last_num_reg <= value;
        end
    end

endmodule

[rtl/cbd_back.sv]
// Back end: holds the cached digits, applies increments, runs the
// shift-and-add-3 conversion and drives the output register. Depends on cbd_pkg.
module cbd_back #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cbd_pkg::fifo_stat_t    q_stat,
    input  cbd_pkg::item_kind_t    q_kind,
    input  logic [VALUE_BITS-1:0]  q_value,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [39:0]            bcd_digits,
    output logic [3:0]             digit_count
);
    import cbd_pkg::*;

    localparam int BCD_W  = 4 * MAX_DIGITS;
    localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W = $clog2(VALUE_BITS);
    localparam int PACK_W = (BCD_W > 40) ? BCD_W : 40;
    localparam int CPAD_W = (LEN_W > 4) ? LEN_W : 4;

    back_state_t state_reg, state_next;

    logic [MAX_DIGITS-1:0][3:0] digits_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [MAX_DIGITS-1:0][3:0] conv_reg;
    logic                       ovf_reg;
    logic [VALUE_BITS-1:0]      shift_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       out_valid_reg;
    logic [BCD_W-1:0]           out_bcd_reg;
    logic [LEN_W-1:0]           out_len_reg;

    logic out_free;
    logic load_hit, load_inc, start_conv, do_step, finish;

    // Decimal increment of the cached digits.
    logic [MAX_DIGITS:0]        carry;
    logic [MAX_DIGITS-1:0][3:0] inc_digits;
    logic                       lengthen;

    // One shift-and-add-3 step and the length of the converted digits.
    logic [MAX_DIGITS-1:0][3:0] adj_digits;
    logic [LEN_W-1:0]           conv_len;

    logic [PACK_W-1:0]          bcd_wide;
    logic [CPAD_W-1:0]          len_wide;
    logic                       upper_clear;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        carry[0] = 1'b1;
        lengthen = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            carry[i+1] = carry[i] && (digits_reg[i] == 4'd9);
            if (carry[i])
            begin
                inc_digits[i] = (digits_reg[i] == 4'd9) ? 4'd0 : digits_reg[i] + 4'd1;
            end
            else
            begin
                inc_digits[i] = digits_reg[i];
            end
            // The carry lands on the zero digit just above the length.
            if (carry[i] && (len_reg == LEN_W'(i)))
            begin
                lengthen = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (conv_reg[i] inside {[4'd5:4'd15]})
            begin
                adj_digits[i] = conv_reg[i] + 4'd3;
            end
            else
            begin
                adj_digits[i] = conv_reg[i];
            end
        end
    end

    always_comb
    begin
        conv_len = LEN_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (conv_reg[i] != 4'd0)
            begin
                conv_len = LEN_W'(i + 1);
            end
        end
        // A bit carried out of the top digit means the number had more digits.
        if (ovf_reg)
        begin
            conv_len = LEN_W'(MAX_DIGITS);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && out_free && (q_kind == KIND_FULL))
                begin
                    state_next = BK_CONV;
                end
            end
            BK_CONV:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb
    begin
        pop        = 1'b0;
        load_hit   = 1'b0;
        load_inc   = 1'b0;
        start_conv = 1'b0;
        do_step    = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop = 1'b1;
                    case (q_kind)
                        KIND_HIT:  load_hit   = 1'b1;
                        KIND_INC:  load_inc   = 1'b1;
                        default:   start_conv = 1'b1;
                    endcase
                end
            end
            BK_CONV:
            begin
                do_step = 1'b1;
            end
            BK_DONE:
            begin
                finish = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            digits_reg    <= '0;
            len_reg       <= LEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_inc)
            begin
                digits_reg <= inc_digits;
                len_reg    <= len_reg + LEN_W'(lengthen);
            end
            else if (finish)
            begin
                digits_reg <= conv_reg;
                len_reg    <= conv_len;
            end
            if (load_hit || load_inc || finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_conv)
        begin
            shift_reg <= q_value;
            conv_reg  <= '0;
            ovf_reg   <= 1'b0;
            step_reg  <= STEP_W'(VALUE_BITS - 1);
        end
        else if (do_step)
        begin
            // The top bit of the adjusted digits leaves here and is kept in ovf_reg.
            conv_reg  <= BCD_W'({adj_digits, shift_reg[VALUE_BITS-1]});
            ovf_reg   <= ovf_reg || adj_digits[MAX_DIGITS-1][3];
            shift_reg <= {shift_reg[VALUE_BITS-2:0], 1'b0};
            step_reg  <= step_reg - 1'b1;
        end
        if (load_hit)
        begin
            out_bcd_reg <= digits_reg;
            out_len_reg <= len_reg;
        end
        else if (load_inc)
        begin
            out_bcd_reg <= inc_digits;
            out_len_reg <= len_reg + LEN_W'(lengthen);
        end
        else if (finish)
        begin
            out_bcd_reg <= conv_reg;
            out_len_reg <= conv_len;
        end
    end

    assign bcd_wide    = PACK_W'(out_bcd_reg);
    assign len_wide    = CPAD_W'(out_len_reg);
    assign out_valid   = out_valid_reg;
    assign bcd_digits  = bcd_wide[39:0];
    assign digit_count = len_wide[3:0];

    always_comb
    begin
        upper_clear = 1'b1;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if ((LEN_W'(i) >= len_reg) && (digits_reg[i] != 4'd0))
            begin
                upper_clear = 1'b0;
            end
        end
    end

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) && (len_reg <= LEN_W'(MAX_DIGITS)))
        else $error("cached digit count out of range");

    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n) upper_clear)
        else $error("cached digit above the count is not zero");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_conv_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CONV) && (step_reg == '0) |=> (state_reg == BK_DONE))
        else $error("conversion did not finish after its last step");

endmodule

[rtl/cached_binary_to_decimal_digits.sv]
// Top level of the cached binary-to-decimal converter: front, queue, back.
// Depends on cbd_pkg, cbd_front, cbd_fifo and cbd_back.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_ready, value             | input beat
//  out     | out_valid, out_ready, bcd_digits,     | output beat
//          | digit_count                           |
//
// A repeated number or the previous number plus one is served from the cached
// digits in the back, so such beats flow at one per cycle while out_ready is
// high and no conversion is running. Any other number runs the shift-and-add-3
// loop, one value bit per cycle, in the single iterating converter.
// Reset clears the queue and sets the cache to the number 0 as the digit "0".
// A two-entry queue lets the front keep accepting beats while the back
// converts or while a finished result waits in the output register.
module cached_binary_to_decimal_digits #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [39:0]           bcd_digits,
    output logic [3:0]            digit_count
);
    import cbd_pkg::*;

    localparam int KIND_W  = $bits(item_kind_t);
    localparam int ENTRY_W = KIND_W + VALUE_BITS;

    // The front classifies against its own copy of the last number, so the
    // queue carries how each beat is to be handled along with the number.
    logic                  push;
    item_kind_t            push_kind;
    logic [VALUE_BITS-1:0] push_value;
    logic                  pop;
    logic [ENTRY_W-1:0]    rd_entry;
    fifo_stat_t            q_stat;
    item_kind_t            q_kind;
    logic [VALUE_BITS-1:0] q_value;

    cbd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .q_stat     (q_stat),
        .push       (push),
        .push_kind  (push_kind),
        .push_value (push_value)
    );

    cbd_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({push_kind, push_value}),
        .pop     (pop),
        .rd_data (rd_entry),
        .stat    (q_stat)
    );

    assign q_kind  = item_kind_t'(rd_entry[ENTRY_W-1:VALUE_BITS]);
    assign q_value = rd_entry[VALUE_BITS-1:0];

    cbd_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_kind      (q_kind),
        .q_value     (q_value),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bcd_digits  (bcd_digits),
        .digit_count (digit_count)
    );

endmodule
